/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. They expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// cons must hold in the same cycle whenever ante holds
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// cons must hold in the cycle after ante holds
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/b64e_pkg.sv */
// ----------------------------------------------------------------------------
// b64e_pkg
// Types, constants and the sextet-to-character map of the Base64 encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

    localparam int unsigned B64E_QUEUE_DEPTH = 4;
    localparam logic [7:0]  PAD_CHAR         = 8'h3D;

    // Characters produced by one input byte, in emit order
    typedef struct packed {
        logic [3:0][7:0] chars;
        logic [1:0]      last_idx;   // index of the final valid character
        logic            eom;        // job closes the message
    } b64e_job_t;

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26)
        begin
            c = 8'd65 + {2'b00, v};
        end
        else if (v < 6'd52)
        begin
            c = 8'd71 + {2'b00, v};          // 'a' - 26
        end
        else if (v < 6'd62)
        begin
            c = {2'b00, v} - 8'd4;           // '0' - 52
        end
        else if (v == 6'd62)
        begin
            c = 8'h2B;
        end
        else
        begin
            c = 8'h2F;
        end
        return c;
    endfunction

endpackage

/* hdl/b64e_front.sv */
// ----------------------------------------------------------------------------
// b64e_front
// Accepts raw bytes, tracks the group phase and builds character jobs.
// ----------------------------------------------------------------------------
module b64e_front
    import b64e_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      take,
    input  logic [7:0] data_byte,
    input  logic      last_byte,
    output b64e_job_t job
);

    logic [1:0] phase_reg, phase_next;
    logic [3:0] carry_reg, carry_next;

    always_comb
    begin
        job.chars    = {4{PAD_CHAR}};
        job.last_idx = 2'd0;
        job.eom      = last_byte;
        phase_next   = phase_reg;
        carry_next   = carry_reg;
        case (phase_reg)
            2'd1:
            begin
                job.chars[0] = b64_char({carry_reg[1:0], data_byte[7:4]});
                if (last_byte)
                begin
                    job.chars[1] = b64_char({data_byte[3:0], 2'b00});
                    job.last_idx = 2'd2;
                end
                carry_next = data_byte[3:0];
                phase_next = 2'd2;
            end
            2'd2:
            begin
                job.chars[0] = b64_char({carry_reg, data_byte[7:6]});
                job.chars[1] = b64_char(data_byte[5:0]);
                job.last_idx = 2'd1;
                carry_next   = 4'd0;
                phase_next   = 2'd0;
            end
            default:
            begin
                // phase three is treated as the start of a group
                job.chars[0] = b64_char(data_byte[7:2]);
                if (last_byte)
                begin
                    job.chars[1] = b64_char({data_byte[1:0], 4'b0000});
                    job.last_idx = 2'd3;
                end
                carry_next = {2'b00, data_byte[1:0]};
                phase_next = 2'd1;
            end
        endcase
        if (last_byte)
        begin
            phase_next = 2'd0;
            carry_next = 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 2'd0;
            carry_reg <= 4'd0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            carry_reg <= carry_next;
        end
    end

endmodule

/* hdl/b64e_queue.sv */
// ----------------------------------------------------------------------------
// b64e_queue
// Short job queue between the front and back halves of the encoder.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module b64e_queue
    import b64e_pkg::*;
#(
    parameter int unsigned DEPTH = B64E_QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  b64e_job_t push_job,
    input  logic      pop,
    output b64e_job_t head,
    output logic      full,
    output logic      empty
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    b64e_job_t         slot_reg [DEPTH];
    logic [AW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]     count_reg;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `ASSERT_ALWAYS(a_no_overflow, !(push && full), "queue push while full")
    `ASSERT_ALWAYS(a_no_underflow, !(pop && empty), "queue pop while empty")
    `ASSERT_ALWAYS(a_count_bound, count_reg <= CW'(DEPTH), "queue count past depth")

endmodule

/* hdl/b64e_back.sv */
// ----------------------------------------------------------------------------
// b64e_back
// Walks the head job one character per beat into the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module b64e_back
    import b64e_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  b64e_job_t  head,
    input  logic       empty,
    output logic       pop,
    input  logic       out_stall,
    output logic       out_valid,
    output logic [7:0] out_char,
    output logic       end_of_text
);

    logic [1:0] idx_reg;
    logic       valid_reg;
    logic [7:0] char_reg;
    logic       eot_reg;
    logic       load;
    logic       at_end;

    assign load   = !valid_reg || !out_stall;
    assign at_end = (idx_reg == head.last_idx);
    assign pop    = load && !empty && at_end;

    assign out_valid   = valid_reg;
    assign out_char    = char_reg;
    assign end_of_text = eot_reg;

    always_ff @(posedge clk)
    begin
        if (load && !empty)
        begin
            char_reg <= head.chars[idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
            eot_reg   <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= !empty;
            eot_reg   <= !empty && at_end && head.eom;
            if (!empty)
            begin
                // advance within the job, rewind on its last character
                idx_reg <= at_end ? 2'd0 : idx_reg + 2'd1;
            end
        end
    end

    `ASSERT_ALWAYS(a_idx_bound, empty || idx_reg <= head.last_idx, "index past job end")
    `ASSERT_IMPLY(a_eot_valid, eot_reg, valid_reg, "end mark without a beat")
    `ASSERT_NEXT(a_pop_rewind, pop, idx_reg == 2'd0, "index not rewound after pop")

endmodule

/* hdl/base64_stream_encoder_top.sv */
// ----------------------------------------------------------------------------
// base64_stream_encoder_top
// Byte-stream Base64 encoder with '=' padding and an end-of-message mark.
// ----------------------------------------------------------------------------
// Input channel: data_byte with last_byte, taken on in_valid high, in_stall low.
// Output channel: out_char with end_of_text, taken on out_valid high,
// out_stall low. end_of_text marks the final character of each message.
// Each byte becomes a job of one to four characters in a short queue; the
// back end sends one character per unstalled cycle from the queue head.
// The first character of a byte is registered in the queue slot and then
// in the output register before it is valid.
// Throughput: one character per cycle while out_stall is low, set by the
// single output register.
// in_stall rises only when the job queue is full.
// Reset clears the group phase, the carried bits, the queue and the output.
// While the receiver stalls, the output beat holds and the front keeps
// taking bytes until the queue fills.
// ----------------------------------------------------------------------------
module base64_stream_encoder_top
    import b64e_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = B64E_QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_char,
    output logic       end_of_text
);

    b64e_job_t job;
    b64e_job_t head;
    logic      take;
    logic      full;
    logic      empty;
    logic      pop;

    assign in_stall = full;
    assign take     = in_valid && !full;

    b64e_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .job       (job)
    );

    b64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (take),
        .push_job (job),
        .pop      (pop),
        .head     (head),
        .full     (full),
        .empty    (empty)
    );

    b64e_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .empty       (empty),
        .pop         (pop),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .out_char    (out_char),
        .end_of_text (end_of_text)
    );

endmodule
